// ----- hdl/anchor_box_landmark_decoder_top_assert.svh -----
// Assertion helpers for the decoder top. Both expect clk and arst_n in scope.
`ifndef ANCHOR_BOX_LANDMARK_DECODER_TOP_ASSERT_SVH
`define ANCHOR_BOX_LANDMARK_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ABLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ABLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/abld_pkg.sv -----
package abld_pkg;

	localparam int NET_WIDTH_DEF     = 640;
	localparam int NET_HEIGHT_DEF    = 640;
	localparam int FINEST_STRIDE_DEF = 8;

	localparam int VALUES_PER_CELL = 17;
	localparam int VALUE_SCORE     = 4;
	localparam int VALUE_CLASS0    = 15;
	localparam int NUM_SIGMOIDS    = 5;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 60;
	localparam int ANC_FIELD_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHORS_SMALL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHORS_MID    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHORS_COARSE = 3'd5;

	localparam logic [2:0] PART_CORNER = 3'd0;
	localparam logic [2:0] PART_SIZE   = 3'd1;
	localparam logic [2:0] PART_LAST   = 3'd6;

	localparam int DIVIDEND_W = 33;
	localparam int DIVISOR_W  = 18;
	localparam int QUOT_W     = 17;
	localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);

	typedef struct packed {
		logic signed [15:0] raw_value;
		logic               frame_start;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         part;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic [15:0]        obj_score;
		logic               best_class;
		logic [14:0]        cell_number;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic [QUOT_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_SG_MUL,
		ST_SG_FRAC,
		ST_SG_EXP,
		ST_SG_DIV,
		ST_SG_END,
		ST_JST,
		ST_IST,
		ST_CX,
		ST_CY,
		ST_W1,
		ST_W2,
		ST_H1,
		ST_H2,
		ST_X0,
		ST_Y0,
		ST_X1,
		ST_Y1,
		ST_LX1,
		ST_LX2,
		ST_LY1,
		ST_LY2,
		ST_TAKE_Y,
		ST_EMIT
	} abld_state_t;

	// round(65536 * 2^(-k/16))
	function automatic logic [16:0] exp2_entry(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			5'd16: v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/abld_divider.sv -----
module abld_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  abld_pkg::div_req_t req,
	output abld_pkg::div_rsp_t rsp
);
	import abld_pkg::*;

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [QUOT_W-1:0]    num_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIVISOR_W:0]   trial;
	logic                 fits;

	// restoring radix-2 step: shift in one dividend bit, subtract if it fits
	assign trial = {rem_q, num_q[QUOT_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(QUOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= DIVISOR_W'(req.dividend[DIVIDEND_W-1:QUOT_W]);
			num_q     <= req.dividend[QUOT_W-1:0];
			divisor_q <= req.divisor;
			quot_q    <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? DIVISOR_W'(trial - {1'b0, divisor_q}) : DIVISOR_W'(trial);
			num_q  <= {num_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quot_q;

endmodule

// ----- hdl/anchor_box_landmark_decoder_top.sv -----
// Face/plate detection head decoder. Head values enter one per transfer, 17 per grid cell,
// in level, anchor, row, column order; frame_start on a value makes it value 0 of cell 0.
// The first 16 values of a cell are taken one per cycle. The 17th starts the decode and
// holds in_stall high until it is done: the objectness sigmoid runs first (two passes
// through the shared multiplier and a 17-step radix-2 divider that is waited on), and a
// cell below the score threshold is dropped there. A cell that passes runs four more
// sigmoids, eight multiplier steps for the box, then four to six steps per result, the
// emit step waiting while the output register is held by out_stall. The shared
// multiplier is 32x18. Seven results per passing cell leave through one output register:
// corner, size, then five landmarks, last marking the seventh. Coordinates are truncated
// toward zero and saturate to 16 bits. Configuration writes take effect at once and belong
// only to idle periods.
module anchor_box_landmark_decoder_top #(
	parameter int NET_WIDTH     = abld_pkg::NET_WIDTH_DEF,
	parameter int NET_HEIGHT    = abld_pkg::NET_HEIGHT_DEF,
	parameter int FINEST_STRIDE = abld_pkg::FINEST_STRIDE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  abld_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output abld_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [abld_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [abld_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import abld_pkg::*;

	localparam int COLS0    = NET_WIDTH / FINEST_STRIDE;
	localparam int COLS1    = NET_WIDTH / (FINEST_STRIDE * 2);
	localparam int COLS2    = NET_WIDTH / (FINEST_STRIDE * 4);
	localparam int ROWS0    = NET_HEIGHT / FINEST_STRIDE;
	localparam int ROWS1    = NET_HEIGHT / (FINEST_STRIDE * 2);
	localparam int ROWS2    = NET_HEIGHT / (FINEST_STRIDE * 4);
	localparam int COL_W    = $clog2(COLS0);
	localparam int ROW_W    = $clog2(ROWS0);
	localparam int STRIDE_W = $clog2(FINEST_STRIDE * 4 + 1);
	localparam int POS_W    = $clog2(VALUES_PER_CELL);
	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = 18;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	function automatic int cols_of(input logic [1:0] l);
		case (l)
			2'd0:    return COLS0;
			2'd1:    return COLS1;
			default: return COLS2;
		endcase
	endfunction

	function automatic int rows_of(input logic [1:0] l);
		case (l)
			2'd0:    return ROWS0;
			2'd1:    return ROWS1;
			default: return ROWS2;
		endcase
	endfunction

	function automatic logic lvl_ok(input logic [1:0] l);
		return (cols_of(l) != 0) && (rows_of(l) != 0);
	endfunction

	// next level that has a grid, skipping empty ones
	function automatic logic [1:0] next_lvl(input logic [1:0] l);
		logic [1:0] l1;
		logic [1:0] l2;
		l1 = (l >= 2'd2) ? 2'd0 : l + 2'd1;
		l2 = (l1 >= 2'd2) ? 2'd0 : l1 + 2'd1;
		if (lvl_ok(l1)) return l1;
		if (lvl_ok(l2)) return l2;
		return l;
	endfunction

	// divide by 2^n, rounding toward zero
	function automatic logic signed [PROD_W-1:0] trunc_sh(input logic signed [PROD_W-1:0] p,
			input int unsigned n);
		logic signed [PROD_W-1:0] bias;
		bias = p[PROD_W-1] ? $signed((PROD_W'(1) << n) - PROD_W'(1)) : '0;
		return (p + bias) >>> n;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] p);
		if (p > $signed(PROD_W'(32767))) return 16'sh7FFF;
		if (p < -$signed(PROD_W'(32768))) return 16'sh8000;
		return p[15:0];
	endfunction

	// configuration
	logic [15:0]         thr_q, sx_q, sy_q;
	logic [CFG_DATA_W-1:0] anc_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 16'd16384;
			sx_q     <= 16'd256;
			sy_q     <= 16'd256;
			anc_q[0] <= '0;
			anc_q[1] <= '0;
			anc_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCORE_THR:      thr_q    <= cfg_data[15:0];
				REG_SCALE_X:        sx_q     <= cfg_data[15:0];
				REG_SCALE_Y:        sy_q     <= cfg_data[15:0];
				REG_ANCHORS_SMALL:  anc_q[0] <= cfg_data;
				REG_ANCHORS_MID:    anc_q[1] <= cfg_data;
				REG_ANCHORS_COARSE: anc_q[2] <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	abld_state_t state_q, state_d;

	logic             in_xfer;
	logic             cell_end;
	logic [POS_W-1:0] pos_q, pos_e;
	logic [COL_W-1:0] col_q, col_e, col_n;
	logic [ROW_W-1:0] row_q, row_e, row_n;
	logic [1:0]       slot_q, slot_e, slot_n;
	logic [1:0]       lvl_q, lvl_e, lvl_n;
	logic [14:0]      cnt_q, cnt_e;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic [CFG_DATA_W-1:0] anc_sel;

	logic signed [15:0] vals_q [VALUES_PER_CELL];

	assign in_stall = (state_q != ST_LOAD);
	assign in_xfer  = in_valid && !in_stall;

	// frame_start restarts every counter before this value is placed
	assign pos_e    = in_data.frame_start ? '0 : pos_q;
	assign col_e    = in_data.frame_start ? '0 : col_q;
	assign row_e    = in_data.frame_start ? '0 : row_q;
	assign slot_e   = in_data.frame_start ? '0 : slot_q;
	assign lvl_e    = in_data.frame_start ? '0 : lvl_q;
	assign cnt_e    = in_data.frame_start ? '0 : cnt_q;
	assign cell_end = (pos_e == POS_W'(VALUES_PER_CELL - 1));

	// column, row, anchor, level walk
	always_comb begin
		col_inc = {1'b0, col_e} + (COL_W+1)'(1);
		row_inc = {1'b0, row_e} + (ROW_W+1)'(1);
		col_n   = '0;
		row_n   = row_e;
		slot_n  = slot_e;
		lvl_n   = lvl_e;
		if (col_inc < (COL_W+1)'(cols_of(lvl_e))) begin
			col_n = col_inc[COL_W-1:0];
		end else if (row_inc < (ROW_W+1)'(rows_of(lvl_e))) begin
			row_n = row_inc[ROW_W-1:0];
		end else begin
			row_n = '0;
			if (slot_e < 2'd2) begin
				slot_n = slot_e + 2'd1;
			end else begin
				slot_n = '0;
				lvl_n  = next_lvl(lvl_e);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			lvl_q  <= '0;
			cnt_q  <= '0;
		end else if (in_xfer) begin
			if (cell_end) begin
				pos_q  <= '0;
				col_q  <= col_n;
				row_q  <= row_n;
				slot_q <= slot_n;
				lvl_q  <= lvl_n;
				cnt_q  <= cnt_e + 15'd1;
			end else begin
				pos_q  <= pos_e + POS_W'(1);
				col_q  <= col_e;
				row_q  <= row_e;
				slot_q <= slot_e;
				lvl_q  <= lvl_e;
				cnt_q  <= cnt_e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			vals_q[pos_e] <= in_data.raw_value;
		end
	end

	// cell context, held for the whole decode
	logic [COL_W-1:0]       j_q;
	logic [ROW_W-1:0]       i_q;
	logic [STRIDE_W-1:0]    st_q;
	logic [ANC_FIELD_W-1:0] aw_q, ah_q;
	logic [14:0]            cell_q;
	logic                   cls_q;

	always_comb begin
		case (lvl_e)
			2'd0:    anc_sel = anc_q[0];
			2'd1:    anc_sel = anc_q[1];
			default: anc_sel = anc_q[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer && cell_end) begin
			j_q    <= col_e;
			i_q    <= row_e;
			st_q   <= STRIDE_W'(FINEST_STRIDE << lvl_e);
			cell_q <= cnt_e;
			cls_q  <= in_data.raw_value > vals_q[VALUE_CLASS0];
			case (slot_e)
				2'd0: begin
					aw_q <= anc_sel[9:0];
					ah_q <= anc_sel[19:10];
				end
				2'd1: begin
					aw_q <= anc_sel[29:20];
					ah_q <= anc_sel[39:30];
				end
				default: begin
					aw_q <= anc_sel[49:40];
					ah_q <= anc_sel[59:50];
				end
			endcase
		end
	end

	// sequencer control
	logic [2:0] n_q;
	logic [2:0] part_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       out_free;

	// single read port into the cell values
	logic [POS_W-1:0]   rd_idx;
	logic signed [15:0] rd_val;
	logic [16:0]        abs_x;

	always_comb begin
		case (state_q)
			ST_LX1:  rd_idx = POS_W'({part_q, 1'b0}) + POS_W'(1);
			ST_LY1:  rd_idx = POS_W'({part_q, 1'b0}) + POS_W'(2);
			default: rd_idx = (n_q == 3'd0) ? POS_W'(VALUE_SCORE) : POS_W'(n_q - 3'd1);
		endcase
	end

	assign rd_val = vals_q[rd_idx];
	assign abs_x  = rd_val[15] ? 17'(-$signed(17'(rd_val))) : 17'($signed(17'(rd_val)));

	// shared multiplier
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_a_x, mul_b_x;
	logic signed [PROD_W-1:0]  prod_q;

	assign mul_a_x = PROD_W'(mul_a);
	assign mul_b_x = PROD_W'(mul_b);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a_x * mul_b_x;
		end
	end

	// sigmoid datapath
	logic [5:0]    ip_q;
	logic [3:0]    k_q;
	logic [4:0]    k_now;
	logic [16:0]   m_val, e_val;
	logic [15:0]   s_val;
	logic [15:0]   score_q;
	logic [15:0]   sig_q [4];
	div_req_t      div_req;
	div_rsp_t      div_rsp;

	assign k_now = {1'b0, prod_q[19:16]};
	assign m_val = exp2_entry({1'b0, k_q}) - 17'(prod_q[22:6]);
	assign e_val = (ip_q >= 6'd17) ? 17'd0 : (m_val >> ip_q);
	assign s_val = rd_val[15] ? div_rsp.quotient[15:0] :
		(div_rsp.quotient[16] ? 16'hFFFF : div_rsp.quotient[15:0]);

	abld_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// box datapath
	logic signed [31:0]       jst_q, ist_q, cx_q, cy_q, w_q, h_q;
	logic signed [15:0]       px_q, py_q;
	logic signed [PROD_W-1:0] lm_x, lm_y, y_scaled;

	assign lm_x = trunc_sh(prod_q + (PROD_W'(jst_q) <<< 10), 10);
	assign lm_y = trunc_sh(prod_q + (PROD_W'(ist_q) <<< 10), 10);

	always_comb begin
		case (part_q)
			PART_CORNER: y_scaled = trunc_sh(prod_q, 25);
			PART_SIZE:   y_scaled = prod_q >>> 24;
			default:     y_scaled = trunc_sh(prod_q, 8);
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:    if (in_xfer && cell_end) state_d = ST_SG_MUL;
			ST_SG_MUL:  state_d = ST_SG_FRAC;
			ST_SG_FRAC: state_d = ST_SG_EXP;
			ST_SG_EXP:  state_d = ST_SG_DIV;
			ST_SG_DIV:  if (!div_rsp.busy) state_d = ST_SG_END;
			ST_SG_END: begin
				if ((n_q == 3'd0) && (s_val < thr_q)) begin
					state_d = ST_LOAD;
				end else if (n_q == 3'(NUM_SIGMOIDS - 1)) begin
					state_d = ST_JST;
				end else begin
					state_d = ST_SG_MUL;
				end
			end
			ST_JST:     state_d = ST_IST;
			ST_IST:     state_d = ST_CX;
			ST_CX:      state_d = ST_CY;
			ST_CY:      state_d = ST_W1;
			ST_W1:      state_d = ST_W2;
			ST_W2:      state_d = ST_H1;
			ST_H1:      state_d = ST_H2;
			ST_H2:      state_d = ST_X0;
			ST_X0:      state_d = ST_Y0;
			ST_Y0:      state_d = ST_TAKE_Y;
			ST_X1:      state_d = ST_Y1;
			ST_Y1:      state_d = ST_TAKE_Y;
			ST_LX1:     state_d = ST_LX2;
			ST_LX2:     state_d = ST_LY1;
			ST_LY1:     state_d = ST_LY2;
			ST_LY2:     state_d = ST_TAKE_Y;
			ST_TAKE_Y:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					if (part_q == PART_LAST) begin
						state_d = ST_LOAD;
					end else if (part_q == PART_CORNER) begin
						state_d = ST_X1;
					end else begin
						state_d = ST_LX1;
					end
				end
			end
			default:    state_d = ST_LOAD;
		endcase
	end

	// multiplier operands and divider start
	always_comb begin
		mul_en           = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = rd_val[15] ? {e_val, 16'd0} : {1'b1, 32'd0};
		div_req.divisor  = 18'd65536 + 18'(e_val);
		unique case (state_q)
			ST_SG_MUL: begin
				mul_en = 1'b1;
				mul_a  = $signed(32'(abs_x));
				mul_b  = 18'sd1477;
			end
			ST_SG_FRAC: begin
				mul_en = 1'b1;
				mul_a  = $signed(32'(exp2_entry(k_now) - exp2_entry(k_now + 5'd1)));
				mul_b  = $signed(18'(prod_q[15:10]));
			end
			ST_SG_EXP: div_req.start = 1'b1;
			ST_JST: begin
				mul_en = 1'b1;
				mul_a  = $signed(32'(j_q));
				mul_b  = $signed(18'(st_q));
			end
			ST_IST: begin
				mul_en = 1'b1;
				mul_a  = $signed(32'(i_q));
				mul_b  = $signed(18'(st_q));
			end
			ST_CX: begin
				mul_en = 1'b1;
				mul_a  = $signed(32'({sig_q[0], 1'b0})) - 32'sd32768;
				mul_b  = $signed(18'(st_q));
			end
			ST_CY: begin
				mul_en = 1'b1;
				mul_a  = $signed(32'({sig_q[1], 1'b0})) - 32'sd32768;
				mul_b  = $signed(18'(st_q));
			end
			ST_W1: begin
				mul_en = 1'b1;
				mul_a  = $signed(32'({sig_q[2], 1'b0}));
				mul_b  = $signed(18'({sig_q[2], 1'b0}));
			end
			ST_W2: begin
				mul_en = 1'b1;
				mul_a  = $signed(prod_q[47:16]);
				mul_b  = $signed(18'(aw_q));
			end
			ST_H1: begin
				mul_en = 1'b1;
				mul_a  = $signed(32'({sig_q[3], 1'b0}));
				mul_b  = $signed(18'({sig_q[3], 1'b0}));
			end
			ST_H2: begin
				mul_en = 1'b1;
				mul_a  = $signed(prod_q[47:16]);
				mul_b  = $signed(18'(ah_q));
			end
			ST_X0: begin
				mul_en = 1'b1;
				mul_a  = (cx_q <<< 1) - w_q;
				mul_b  = $signed(18'(sx_q));
			end
			ST_Y0: begin
				mul_en = 1'b1;
				mul_a  = (cy_q <<< 1) - h_q;
				mul_b  = $signed(18'(sy_q));
			end
			ST_X1: begin
				mul_en = 1'b1;
				mul_a  = w_q;
				mul_b  = $signed(18'(sx_q));
			end
			ST_Y1: begin
				mul_en = 1'b1;
				mul_a  = h_q;
				mul_b  = $signed(18'(sy_q));
			end
			ST_LX1: begin
				mul_en = 1'b1;
				mul_a  = 32'(rd_val);
				mul_b  = $signed(18'(aw_q));
			end
			ST_LX2: begin
				mul_en = 1'b1;
				mul_a  = lm_x[31:0];
				mul_b  = $signed(18'(sx_q));
			end
			ST_LY1: begin
				mul_en = 1'b1;
				mul_a  = 32'(rd_val);
				mul_b  = $signed(18'(ah_q));
			end
			ST_LY2: begin
				mul_en = 1'b1;
				mul_a  = lm_y[31:0];
				mul_b  = $signed(18'(sy_q));
			end
			default: ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SG_FRAC: begin
				ip_q <= prod_q[25:20];
				k_q  <= prod_q[19:16];
			end
			ST_SG_END: begin
				if (n_q == 3'd0) begin
					score_q <= s_val;
				end else begin
					sig_q[n_q[1:0] - 2'd1] <= s_val;
				end
			end
			ST_IST: jst_q <= prod_q[31:0];
			ST_CX:  ist_q <= prod_q[31:0];
			ST_CY:  cx_q  <= prod_q[31:0] + (jst_q <<< 16);
			ST_W1:  cy_q  <= prod_q[31:0] + (ist_q <<< 16);
			ST_H1:  w_q   <= prod_q[31:0];
			ST_X0:  h_q   <= prod_q[31:0];
			ST_Y0:  px_q  <= sat16(trunc_sh(prod_q, 25));
			ST_Y1:  px_q  <= sat16(prod_q >>> 24);
			ST_LY1: px_q  <= sat16(trunc_sh(prod_q, 8));
			ST_TAKE_Y: py_q <= sat16(y_scaled);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			out_q.part        <= part_q;
			out_q.coord_x     <= px_q;
			out_q.coord_y     <= py_q;
			out_q.obj_score   <= score_q;
			out_q.best_class  <= cls_q;
			out_q.cell_number <= cell_q;
			out_q.last        <= (part_q == PART_LAST);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			n_q         <= '0;
			part_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && cell_end) begin
				n_q <= '0;
			end else if ((state_q == ST_SG_END) && (state_d == ST_SG_MUL)) begin
				n_q <= n_q + 3'd1;
			end
			if (state_q == ST_JST) begin
				part_q <= PART_CORNER;
			end else if ((state_q == ST_EMIT) && out_free) begin
				part_q <= part_q + 3'd1;
			end
			// hold a waiting result, drop it once transferred
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`include "anchor_box_landmark_decoder_top_assert.svh"

	`ABLD_ASSERT_NOW(a_div_idle_in_load, state_q == ST_LOAD, !div_rsp.busy, "divider busy while loading")
	`ABLD_ASSERT_NOW(a_pos_clear_busy, state_q != ST_LOAD, pos_q == '0, "value position not cleared during decode")
	`ABLD_ASSERT_NOW(a_out_from_emit, $rose(out_valid), $past(state_q) == ST_EMIT, "result raised outside emit")
	`ABLD_ASSERT_NEXT(a_div_started, state_q == ST_SG_EXP, div_rsp.busy, "divider did not start")

endmodule

// ----- verif/anchor_box_landmark_decoder_top_tb.sv -----
`timescale 1ns / 100ps

module anchor_box_landmark_decoder_top_tb;
	import abld_pkg::*;

	localparam int NET_W    = 640;
	localparam int NET_H    = 640;
	localparam int STRIDE0  = 8;
	localparam int SETTLE   = 300;
	localparam longint CYCLE_LIMIT = 1500000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Decoder mirror: cell buffer, grid position and register copies
	logic [15:0] cell_buf [VALUES_PER_CELL];
	int unsigned pos_in_cell, col_pos, row_pos, slot_pos, level_pos, cell_count;
	logic [15:0] thr_reg, sx_reg, sy_reg;
	logic [59:0] anc_reg [3];

	out_item_t   decoded_q [$];
	int          errors = 0;
	longint      cycles = 0;
	bit          quiet = 1'b0;

	// round(65536 * 2^(-k/16))
	longint exp2_q16 [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
		46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

	anchor_box_landmark_decoder_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Hard stop if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint sigmoid_q16(longint x);
		longint a, t, ip, fr, k, lo, m, e, s;
		a = (x < 0) ? -x : x;
		t = (a * 1477) >>> 10;
		ip = t >>> 10;
		fr = t & 1023;
		k = fr >>> 6;
		lo = fr & 63;
		m = exp2_q16[k] - (((exp2_q16[k] - exp2_q16[k + 1]) * lo) >>> 6);
		e = (ip >= 17) ? 0 : (m >>> ip);
		if (x >= 0) begin
			s = (64'sd1 <<< 32) / (65536 + e);
			if (s > 65535) s = 65535;
		end else begin
			s = (e * 65536) / (65536 + e);
		end
		return s;
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic longint head_val(int k);
		return longint'($signed(cell_buf[k]));
	endfunction

	function automatic int unsigned grid_cols(int unsigned lvl);
		return NET_W / (STRIDE0 << lvl);
	endfunction

	function automatic int unsigned grid_rows(int unsigned lvl);
		return NET_H / (STRIDE0 << lvl);
	endfunction

	task automatic step_grid();
		col_pos++;
		if (col_pos < grid_cols(level_pos)) return;
		col_pos = 0;
		row_pos++;
		if (row_pos < grid_rows(level_pos)) return;
		row_pos = 0;
		slot_pos++;
		if (slot_pos < 3) return;
		slot_pos = 0;
		for (int n = 0; n < 3; n++) begin
			level_pos = (level_pos + 1) % 3;
			if (grid_cols(level_pos) != 0 && grid_rows(level_pos) != 0) break;
		end
	endtask

	// Absorb one head value; a completed cell at or above threshold queues seven points
	task automatic absorb_value(logic [15:0] v, bit fs);
		longint score, cx, cy, d, w, h, aw, ah, j, i, st, lx, ly;
		longint xs [7], ys [7];
		logic [59:0] anc;
		int unsigned cell_idx;
		bit cls;
		out_item_t o;
		if (fs) begin
			pos_in_cell = 0; col_pos = 0; row_pos = 0;
			slot_pos = 0; level_pos = 0; cell_count = 0;
		end
		cell_buf[pos_in_cell] = v;
		pos_in_cell++;
		if (pos_in_cell < VALUES_PER_CELL) return;
		pos_in_cell = 0;
		cell_idx = cell_count;
		j = col_pos;
		i = row_pos;
		st = STRIDE0 << level_pos;
		anc = anc_reg[level_pos];
		aw = (anc >> (20 * slot_pos)) & 10'h3ff;
		ah = (anc >> (20 * slot_pos + 10)) & 10'h3ff;
		step_grid();
		cell_count = (cell_count + 1) & 15'h7fff;
		cls = head_val(16) > head_val(15);
		score = sigmoid_q16(head_val(VALUE_SCORE));
		if (score < longint'(thr_reg)) return;
		cx = (2 * sigmoid_q16(head_val(0)) - 32768 + j * 65536) * st;
		cy = (2 * sigmoid_q16(head_val(1)) - 32768 + i * 65536) * st;
		d = 2 * sigmoid_q16(head_val(2));
		w = ((d * d) >>> 16) * aw;
		d = 2 * sigmoid_q16(head_val(3));
		h = ((d * d) >>> 16) * ah;
		xs[0] = ((2 * cx - w) * longint'(sx_reg)) / (64'sd1 <<< 25);
		ys[0] = ((2 * cy - h) * longint'(sy_reg)) / (64'sd1 <<< 25);
		xs[1] = (w * longint'(sx_reg)) / (64'sd1 <<< 24);
		ys[1] = (h * longint'(sy_reg)) / (64'sd1 <<< 24);
		for (int p = 0; p < 5; p++) begin
			lx = (head_val(5 + 2 * p) * aw + j * st * 1024) / 1024;
			ly = (head_val(6 + 2 * p) * ah + i * st * 1024) / 1024;
			xs[2 + p] = (lx * longint'(sx_reg)) / 256;
			ys[2 + p] = (ly * longint'(sy_reg)) / 256;
		end
		for (int n = 0; n < 7; n++) begin
			o.part = n[2:0];
			o.coord_x = clamp16(xs[n]);
			o.coord_y = clamp16(ys[n]);
			o.obj_score = score[15:0];
			o.best_class = cls;
			o.cell_number = cell_idx[14:0];
			o.last = (n[2:0] == PART_LAST);
			decoded_q.insert(decoded_q.size(), o);
		end
	endtask

	// Check every result transfer against the oldest decoded point, then pick next stall
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				$error("result with nothing expected: part %0d", out_data.part);
				errors++;
			end else begin
				e = decoded_q.pop_front();
				if (out_data.part !== e.part) begin
					$error("part exp %0d got %0d", e.part, out_data.part); errors++;
				end
				if (out_data.coord_x !== e.coord_x) begin
					$error("coord_x exp %0d got %0d", e.coord_x, out_data.coord_x); errors++;
				end
				if (out_data.coord_y !== e.coord_y) begin
					$error("coord_y exp %0d got %0d", e.coord_y, out_data.coord_y); errors++;
				end
				if (out_data.obj_score !== e.obj_score) begin
					$error("obj_score exp %0d got %0d", e.obj_score, out_data.obj_score);
					errors++;
				end
				if (out_data.best_class !== e.best_class) begin
					$error("best_class exp %0d got %0d", e.best_class, out_data.best_class);
					errors++;
				end
				if (out_data.cell_number !== e.cell_number) begin
					$error("cell_number exp %0d got %0d", e.cell_number, out_data.cell_number);
					errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_data.last); errors++;
				end
			end
		end
		out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 34);
	end

	// Offer one head value, with a random gap first; hold it until the transfer
	task automatic send_value(logic [15:0] v, bit fs);
		while (!quiet && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.raw_value <= v;
		in_data.frame_start <= fs;
		do @(posedge clk); while (in_stall);
		absorb_value(v, fs);
	endtask

	// Send a full cell; score drives value 4, everything else is random
	task automatic send_cell(bit fs, logic [15:0] score_val);
		for (int k = 0; k < VALUES_PER_CELL; k++)
			send_value((k == VALUE_SCORE) ? score_val : 16'($urandom), fs && k == 0);
	endtask

	task automatic send_fill(bit fs, logic [15:0] v, logic [15:0] c15, logic [15:0] c16);
		for (int k = 0; k < VALUES_PER_CELL; k++)
			send_value((k == VALUE_CLASS0) ? c15 : (k == VALUE_CLASS0 + 1) ? c16 : v,
				fs && k == 0);
	endtask

	// Hold until every decoded point has left and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [59:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SCORE_THR:      thr_reg = v[15:0];
			REG_SCALE_X:        sx_reg = v[15:0];
			REG_SCALE_Y:        sy_reg = v[15:0];
			REG_ANCHORS_SMALL:  anc_reg[0] = v;
			REG_ANCHORS_MID:    anc_reg[1] = v;
			REG_ANCHORS_COARSE: anc_reg[2] = v;
			default: ;
		endcase
	endtask

	function automatic logic [59:0] rand60();
		return 60'({$urandom, $urandom});
	endfunction

	task automatic random_setup();
		write_reg(REG_SCORE_THR, 60'($urandom_range(65535)));
		write_reg(REG_SCALE_X, 60'($urandom_range(100) < 20 ? 16'($urandom) : $urandom_range(640)));
		write_reg(REG_SCALE_Y, 60'($urandom_range(100) < 20 ? 16'($urandom) : $urandom_range(640)));
		write_reg(REG_ANCHORS_SMALL, rand60());
		write_reg(REG_ANCHORS_MID, rand60());
		write_reg(REG_ANCHORS_COARSE, rand60());
	endtask

	// Reset values: zero anchors, unit scales, quarter threshold
	task automatic test_reset_defaults();
		send_cell(1'b1, 16'sd4000);
		send_cell(1'b0, -16'sd4000);
		send_cell(1'b0, 16'sd0);
		drain();
	endtask

	// Field and register extremes: saturation, class ties, full and zero scales
	task automatic test_extremes();
		write_reg(REG_SCORE_THR, 60'd0);
		write_reg(REG_SCALE_X, 60'hffff);
		write_reg(REG_SCALE_Y, 60'hffff);
		write_reg(REG_ANCHORS_SMALL, {60{1'b1}});
		write_reg(REG_ANCHORS_MID, {60{1'b1}});
		write_reg(REG_ANCHORS_COARSE, {60{1'b1}});
		send_fill(1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
		send_fill(1'b0, 16'h8000, 16'h8000, 16'h7fff);
		send_fill(1'b0, 16'h0000, 16'h0001, 16'h0000);
		drain();
		write_reg(REG_SCORE_THR, 60'hffff);
		write_reg(REG_SCALE_X, 60'd0);
		write_reg(REG_SCALE_Y, 60'd1);
		send_fill(1'b1, 16'h7fff, 16'h1234, 16'h1235);
		send_fill(1'b0, 16'h0000, 16'h0000, 16'h0000);
		drain();
	endtask

	// Indexes past the last register must leave all settings alone
	task automatic test_unused_index();
		write_reg(3'd6, rand60());
		write_reg(3'd7, rand60());
		write_reg(REG_SCORE_THR, 60'd0);
		write_reg(REG_SCALE_X, 60'd256);
		send_cell(1'b1, 16'h7fff);
		drain();
	endtask

	// One stretch with no idling on either side, cells back to back
	task automatic test_no_idle();
		random_setup();
		write_reg(REG_SCORE_THR, 60'd60000);
		quiet = 1'b1;
		send_cell(1'b1, 16'($urandom));
		for (int c = 1; c < 4; c++)
			send_cell(1'b0, ($urandom_range(2) == 0) ? 16'h7800 : 16'($urandom));
		quiet = 1'b0;
		drain();
	endtask

	// Random phases of well-formed cells, with frame restarts and some noise
	task automatic test_random();
		int sent;
		bit paused;
		sent = 0;
		paused = 1'b0;
		while (sent < 130) begin
			random_setup();
			for (int c = 0; c < 3; c++) begin
				if ($urandom_range(9) == 0) begin
					send_value(16'($urandom), 1'b1);
					sent++;
				end else begin
					send_cell(c == 0 || $urandom_range(5) == 0, 16'($urandom));
					sent += VALUES_PER_CELL;
				end
				if (!paused && sent > 60) begin
					paused = 1'b1;
					in_valid <= 1'b0;
					while (decoded_q.size() != 0) @(posedge clk);
				end
			end
			drain();
		end
	endtask

	initial begin
		thr_reg = 16'd16384;
		sx_reg = 16'd256;
		sy_reg = 16'd256;
		for (int n = 0; n < 3; n++) anc_reg[n] = '0;
		for (int n = 0; n < VALUES_PER_CELL; n++) cell_buf[n] = '0;
		pos_in_cell = 0; col_pos = 0; row_pos = 0;
		slot_pos = 0; level_pos = 0; cell_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extremes();
		test_unused_index();
		test_no_idle();
		test_random();
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
